### rtl/pi_duty_cycle_regulator_top_assert.svh
// Assertion macros used by the checker file of the duty-cycle regulator.
`ifndef PI_DUTY_CYCLE_REGULATOR_TOP_ASSERT_SVH
`define PI_DUTY_CYCLE_REGULATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PDCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PDCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/pdcr_pkg.sv
// Shared widths, register indexes and types of the duty-cycle regulator.
package pdcr_pkg;

  localparam int FB_BITS   = 12;
  localparam int ERR_BITS  = 13;
  localparam int PDIV_BITS = 12;
  localparam int DIV_BITS  = 24;
  localparam int DUTY_BITS = 9;
  localparam int INTE_BITS = 16;
  localparam int SUM_BITS  = 18;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [2:0] REG_SETPOINT    = 3'd0;
  localparam logic [2:0] REG_ERROR_UPPER = 3'd1;
  localparam logic [2:0] REG_ERROR_LOWER = 3'd2;
  localparam logic [2:0] REG_PROP_DIV    = 3'd3;
  localparam logic [2:0] REG_INTEG_DIV   = 3'd4;
  localparam logic [2:0] REG_DUTY_UPPER  = 3'd5;
  localparam logic [2:0] REG_DUTY_LOWER  = 3'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/pdcr_divider.sv
// Iterative restoring divider: one quotient bit per cycle, unsigned operands.
module pdcr_divider
  import pdcr_pkg::*;
#(
  parameter int NBITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NBITS-1:0]    dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic [NBITS-1:0]    quotient,
  output div_status_t         status
);

  localparam int CW = $clog2(NBITS + 1);

  logic [NBITS-1:0]    acc;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] dsr;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic                done;

  logic [DIV_BITS:0]   trial;
  logic                qbit;
  logic [DIV_BITS:0]   rem_next;

  // The dividend shifts out at the top of acc while quotient bits enter below.
  always_comb begin
    trial    = {rem, acc[NBITS-1]};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? (trial - {1'b0, dsr}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= CW'(NBITS);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next[DIV_BITS-1:0];
        acc <= {acc[NBITS-2:0], qbit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### rtl/pi_duty_cycle_regulator_top.sv
// Top level of the incremental PI duty-cycle regulator with clamping.
// A sample is accepted only while idle; in_stall is high until its duty result is registered.
// The shared divider, one quotient bit per cycle, is used twice per sample.
// A finished result waits in the output register while the next sample is accepted.
// Synchronous reset clears the integrator, the duty and the registers to defaults.
module pi_duty_cycle_regulator_top
  import pdcr_pkg::*;
#(
  parameter int INTEGRATOR_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FB_BITS-1:0]   feedback,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DUTY_BITS-1:0] duty_cycle,
  output logic                 at_upper_limit,
  output logic                 at_lower_limit,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int IB = INTEGRATOR_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INTEG,
    S_PDIV,
    S_IDIV,
    S_SUM
  } state_t;

  // Configuration registers
  logic [FB_BITS-1:0]   setpoint;
  logic [ERR_BITS-1:0]  error_upper;
  logic [ERR_BITS-1:0]  error_lower;
  logic [PDIV_BITS-1:0] prop_divisor;
  logic [DIV_BITS-1:0]  integral_divisor;
  logic [DUTY_BITS-1:0] duty_upper;
  logic [DUTY_BITS-1:0] duty_lower;

  logic [2:0] reg_idx;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint         <= '0;
      error_upper      <= 13'h0FFF;
      error_lower      <= 13'h1000;
      prop_divisor     <= 12'd1;
      integral_divisor <= 24'd1;
      duty_upper       <= 9'h1FF;
      duty_lower       <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_SETPOINT:    setpoint         <= pwdata[FB_BITS-1:0];
        REG_ERROR_UPPER: error_upper      <= pwdata[ERR_BITS-1:0];
        REG_ERROR_LOWER: error_lower      <= pwdata[ERR_BITS-1:0];
        REG_PROP_DIV:    prop_divisor     <= pwdata[PDIV_BITS-1:0];
        REG_INTEG_DIV:   integral_divisor <= pwdata[DIV_BITS-1:0];
        REG_DUTY_UPPER:  duty_upper       <= pwdata[DUTY_BITS-1:0];
        REG_DUTY_LOWER:  duty_lower       <= pwdata[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SETPOINT:    prdata = DATA_BITS'(setpoint);
      REG_ERROR_UPPER: prdata = DATA_BITS'(error_upper);
      REG_ERROR_LOWER: prdata = DATA_BITS'(error_lower);
      REG_PROP_DIV:    prdata = DATA_BITS'(prop_divisor);
      REG_INTEG_DIV:   prdata = DATA_BITS'(integral_divisor);
      REG_DUTY_UPPER:  prdata = DATA_BITS'(duty_upper);
      REG_DUTY_LOWER:  prdata = DATA_BITS'(duty_lower);
      default:         prdata = '0;
    endcase
  end

  // Datapath state
  state_t                state;
  logic [ERR_BITS-1:0]   err;
  logic [IB-1:0]         integrator;
  logic [DUTY_BITS-1:0]  duty_now;
  logic [ERR_BITS:0]     prop;
  logic [INTE_BITS-1:0]  inte;

  // Error of the incoming sample, clamped upper first and then lower.
  logic signed [ERR_BITS:0] err_raw;
  logic signed [ERR_BITS:0] err_up;
  logic signed [ERR_BITS:0] err_lo;
  logic signed [ERR_BITS:0] err_clamped;

  always_comb begin
    err_raw = $signed({2'b00, setpoint}) - $signed({2'b00, feedback});
    err_up  = $signed({error_upper[ERR_BITS-1], error_upper});
    err_lo  = $signed({error_lower[ERR_BITS-1], error_lower});
    err_clamped = err_raw;
    if (err_clamped > err_up) err_clamped = err_up;
    if (err_clamped < err_lo) err_clamped = err_lo;
  end

  // Saturating integrator update: overflow shows as differing top two bits.
  logic [IB:0]   integ_sum;
  logic [IB-1:0] integ_next;

  always_comb begin
    integ_sum = {integrator[IB-1], integrator}
              + {{(IB + 1 - ERR_BITS){err[ERR_BITS-1]}}, err};
    if (integ_sum[IB] != integ_sum[IB-1]) begin
      integ_next = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
    end else begin
      integ_next = integ_sum[IB-1:0];
    end
  end

  // Divider operands: magnitudes, with a zero divisor acting as one.
  logic [ERR_BITS-1:0] err_mag;
  logic [IB-1:0]       integ_mag;
  logic                div_start;
  logic [IB-1:0]       div_dividend;
  logic [DIV_BITS-1:0] div_divisor;
  logic [IB-1:0]       div_quot;
  div_status_t         div_st;

  assign err_mag   = err[ERR_BITS-1] ? (~err + ERR_BITS'(1)) : err;
  assign integ_mag = integrator[IB-1] ? (~integrator + IB'(1)) : integrator;
  assign div_start = (state == S_INTEG) || ((state == S_PDIV) && div_st.done);

  always_comb begin
    if (state == S_INTEG) begin
      div_dividend = {{(IB - ERR_BITS){1'b0}}, err_mag};
      div_divisor  = (prop_divisor == '0) ? DIV_BITS'(1) : DIV_BITS'(prop_divisor);
    end else begin
      div_dividend = integ_mag;
      div_divisor  = (integral_divisor == '0) ? DIV_BITS'(1) : integral_divisor;
    end
  end

  pdcr_divider #(
    .NBITS(IB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_st)
  );

  // Signed quotients; the integral term saturates to 16 bits.
  logic [ERR_BITS:0]    prop_q;
  logic [INTE_BITS-1:0] inte_q;

  always_comb begin
    prop_q = {1'b0, div_quot[ERR_BITS-1:0]};
    if (err[ERR_BITS-1]) prop_q = ~prop_q + (ERR_BITS + 1)'(1);
    if (integrator[IB-1]) begin
      inte_q = (div_quot > IB'(32768)) ? 16'h8000
                                        : (~div_quot[INTE_BITS-1:0] + INTE_BITS'(1));
    end else begin
      inte_q = (div_quot > IB'(32767)) ? 16'h7FFF : div_quot[INTE_BITS-1:0];
    end
  end

  // New duty: signed sum against the limits, upper test first.
  logic signed [SUM_BITS-1:0] duty_sum;
  logic                       hit_upper;
  logic                       hit_lower;
  logic                       slot_free;

  always_comb begin
    duty_sum  = $signed({{(SUM_BITS - DUTY_BITS){1'b0}}, duty_now})
              + $signed({{(SUM_BITS - ERR_BITS - 1){prop[ERR_BITS]}}, prop})
              + $signed({{(SUM_BITS - INTE_BITS){inte[INTE_BITS-1]}}, inte});
    hit_upper = duty_sum >= $signed({{(SUM_BITS - DUTY_BITS){1'b0}}, duty_upper});
    hit_lower = duty_sum <= $signed({{(SUM_BITS - DUTY_BITS){1'b0}}, duty_lower});
  end

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      integrator <= '0;
      duty_now   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // In S_SUM the output register is handled by the state's own branch.
      if (out_valid && !out_stall && (state != S_SUM)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err   <= err_clamped[ERR_BITS-1:0];
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          integrator <= integ_next;
          state      <= S_PDIV;
        end
        S_PDIV: begin
          if (div_st.done) begin
            prop  <= prop_q;
            state <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_st.done) begin
            inte  <= inte_q;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (slot_free) begin
            if (hit_upper) begin
              duty_now       <= duty_upper;
              duty_cycle     <= duty_upper;
              at_upper_limit <= 1'b1;
              at_lower_limit <= 1'b0;
            end else if (hit_lower) begin
              duty_now       <= duty_lower;
              duty_cycle     <= duty_lower;
              at_upper_limit <= 1'b0;
              at_lower_limit <= 1'b1;
            end else begin
              duty_now       <= duty_sum[DUTY_BITS-1:0];
              duty_cycle     <= duty_sum[DUTY_BITS-1:0];
              at_upper_limit <= 1'b0;
              at_lower_limit <= 1'b0;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/pdcr_checker.sv
// Port-level checker for the duty-cycle regulator, bound to the top level.
`include "pi_duty_cycle_regulator_top_assert.svh"

module pdcr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [8:0] duty_cycle,
  input logic       at_upper_limit,
  input logic       at_lower_limit
);

  // A waiting result keeps its value until it is taken.
  `PDCR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(duty_cycle))

  // A result is never clamped to both limits at once.
  `PDCR_ASSERT_IMP(a_flags_excl, out_valid, !(at_upper_limit && at_lower_limit))

  // Once a request is accepted the block is busy with it.
  `PDCR_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // The result of a request needs the divider, so none appears right after accept.
  `PDCR_ASSERT_NXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind pi_duty_cycle_regulator_top pdcr_checker u_pdcr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .duty_cycle     (duty_cycle),
  .at_upper_limit (at_upper_limit),
  .at_lower_limit (at_lower_limit)
);

### test/pi_duty_cycle_regulator_top_tb.sv
// Self-checking testbench for the PI duty-cycle regulator: directed table, then random phases.
`timescale 1ns / 1ps

module pi_duty_cycle_regulator_top_tb
  import pdcr_pkg::*;
();

  localparam int INTEGRATOR_BITS = 24;
  localparam longint INTEG_MAX = 2 ** (INTEGRATOR_BITS - 1) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 up;
    logic                 lo;
  } duty_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [31:0]        data;
    logic [FB_BITS-1:0] fb;
    logic               known;
    duty_result_t       want;
  } plan_row_t;

  typedef enum logic [2:0] {PH_RANDOM, PH_MIN, PH_MAX, PH_WINDUP_HI, PH_WINDUP_LO} phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FB_BITS-1:0]   feedback = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DUTY_BITS-1:0] duty_cycle;
  logic                 at_upper_limit;
  logic                 at_lower_limit;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Shadow copy of the register file and of the loop state.
  logic [FB_BITS-1:0]   sp_reg;
  logic [ERR_BITS-1:0]  eu_reg;
  logic [ERR_BITS-1:0]  el_reg;
  logic [PDIV_BITS-1:0] pdiv_reg;
  logic [DIV_BITS-1:0]  idiv_reg;
  logic [DUTY_BITS-1:0] du_reg;
  logic [DUTY_BITS-1:0] dl_reg;
  longint               integ_acc;
  logic [DUTY_BITS-1:0] duty_held;

  duty_result_t duty_expected[$];
  duty_result_t seen_want;
  int           mismatches = 0;
  int           idle_cycles = 0;
  logic         calm = 1'b0;

  pi_duty_cycle_regulator_top #(
    .INTEGRATOR_BITS(INTEGRATOR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .feedback(feedback),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .duty_cycle(duty_cycle),
    .at_upper_limit(at_upper_limit),
    .at_lower_limit(at_lower_limit),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic duty_result_t next_duty(input logic [FB_BITS-1:0] fb);
    longint err, prop, inte, sum, pdiv, idiv, eu, el;
    duty_result_t r;
    eu = $signed(eu_reg);
    el = $signed(el_reg);
    err = longint'(sp_reg) - longint'(fb);
    // Upper clamp first, so a crossed lower limit wins.
    if (err > eu) err = eu;
    if (err < el) err = el;
    pdiv = (pdiv_reg == '0) ? 1 : longint'(pdiv_reg);
    prop = err / pdiv;
    integ_acc = integ_acc + err;
    if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
    if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
    idiv = (idiv_reg == '0) ? 1 : longint'(idiv_reg);
    inte = integ_acc / idiv;
    if (inte > 32767) inte = 32767;
    if (inte < -32768) inte = -32768;
    sum = longint'(duty_held) + prop + inte;
    r = '0;
    if (sum >= longint'(du_reg)) begin
      duty_held = du_reg;
      r.up = 1'b1;
    end else if (sum <= longint'(dl_reg)) begin
      duty_held = dl_reg;
      r.lo = 1'b1;
    end else begin
      duty_held = sum[DUTY_BITS-1:0];
    end
    r.duty = duty_held;
    return r;
  endfunction

  function automatic plan_row_t sample_row(input logic [FB_BITS-1:0] fb);
    plan_row_t p;
    p = '0;
    p.kind = ROW_SAMPLE;
    p.fb = fb;
    return p;
  endfunction

  function automatic plan_row_t known_row(input logic [FB_BITS-1:0] fb,
                                          input logic [DUTY_BITS-1:0] duty,
                                          input logic up, input logic lo);
    plan_row_t p;
    p = sample_row(fb);
    p.known = 1'b1;
    p.want.duty = duty;
    p.want.up = up;
    p.want.lo = lo;
    return p;
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [31:0] data);
    plan_row_t p;
    p = '0;
    p.kind = ROW_WRITE;
    p.idx = idx;
    p.data = data;
    return p;
  endfunction

  function automatic logic [FB_BITS-1:0] pick_feedback();
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 55) v = int'(sp_reg) + int'($urandom_range(0, 128)) - 64;
    else if (r < 85) v = int'($urandom_range(0, 4095));
    else v = $urandom_range(0, 1) ? 4095 : 0;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[FB_BITS-1:0];
  endfunction

  // Called at a falling edge; returns at a falling edge with the bus idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SETPOINT:    sp_reg = data[FB_BITS-1:0];
      REG_ERROR_UPPER: eu_reg = data[ERR_BITS-1:0];
      REG_ERROR_LOWER: el_reg = data[ERR_BITS-1:0];
      REG_PROP_DIV:    pdiv_reg = data[PDIV_BITS-1:0];
      REG_INTEG_DIV:   idiv_reg = data[DIV_BITS-1:0];
      REG_DUTY_UPPER:  du_reg = data[DUTY_BITS-1:0];
      REG_DUTY_LOWER:  dl_reg = data[DUTY_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_sample(input logic [FB_BITS-1:0] fb, input logic known,
                             input duty_result_t want);
    int r, gap;
    duty_result_t pred;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!calm && r < 20) gap = $urandom_range(1, 4);
    else if (!calm && r < 22) gap = $urandom_range(5, 80);
    repeat (gap) begin
      in_valid <= 1'b0;
      feedback <= FB_BITS'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    feedback <= fb;
    do @(posedge clk); while (in_stall);
    pred = next_duty(fb);
    duty_expected.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (duty_expected.size() != 0) @(negedge clk);
  endtask

  task automatic random_settings();
    write_reg(REG_SETPOINT, $urandom);
    if ($urandom_range(0, 99) < 80) write_reg(REG_ERROR_UPPER, $urandom_range(0, 4095));
    else write_reg(REG_ERROR_UPPER, $urandom);
    if ($urandom_range(0, 99) < 80)
      write_reg(REG_ERROR_LOWER, 32'(-int'($urandom_range(0, 4096))));
    else write_reg(REG_ERROR_LOWER, $urandom);
    if ($urandom_range(0, 99) < 90)
      write_reg(REG_PROP_DIV, $urandom_range(1, 1 << $urandom_range(0, 12)));
    else write_reg(REG_PROP_DIV, $urandom);
    if ($urandom_range(0, 99) < 90)
      write_reg(REG_INTEG_DIV, $urandom_range(1, 1 << $urandom_range(0, 24)));
    else write_reg(REG_INTEG_DIV, $urandom);
    if ($urandom_range(0, 99) < 80) write_reg(REG_DUTY_UPPER, $urandom_range(256, 511));
    else write_reg(REG_DUTY_UPPER, $urandom);
    if ($urandom_range(0, 99) < 80) write_reg(REG_DUTY_LOWER, $urandom_range(0, 255));
    else write_reg(REG_DUTY_LOWER, $urandom);
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  task automatic run_phase(input phase_t kind, input int n_items);
    logic [FB_BITS-1:0] fb;
    wait_idle();
    case (kind)
      PH_MIN: begin
        write_reg(REG_SETPOINT, 32'd0);
        write_reg(REG_ERROR_UPPER, 32'hFFFF_F000);
        write_reg(REG_ERROR_LOWER, 32'hFFFF_F000);
        write_reg(REG_PROP_DIV, 32'd1);
        write_reg(REG_INTEG_DIV, 32'd1);
        write_reg(REG_DUTY_UPPER, 32'd0);
        write_reg(REG_DUTY_LOWER, 32'd0);
      end
      PH_MAX: begin
        write_reg(REG_SETPOINT, 32'd4095);
        write_reg(REG_ERROR_UPPER, 32'd4095);
        write_reg(REG_ERROR_LOWER, 32'd4095);
        write_reg(REG_PROP_DIV, 32'd4095);
        write_reg(REG_INTEG_DIV, 32'hFF_FFFF);
        write_reg(REG_DUTY_UPPER, 32'd511);
        write_reg(REG_DUTY_LOWER, 32'd511);
      end
      PH_WINDUP_HI: begin
        // Slow loop gains, so the moment the duty turns back shows the integrator value.
        write_reg(REG_SETPOINT, 32'd4095);
        write_reg(REG_ERROR_UPPER, 32'd4095);
        write_reg(REG_ERROR_LOWER, 32'hFFFF_F000);
        write_reg(REG_PROP_DIV, 32'd4095);
        write_reg(REG_INTEG_DIV, 32'd1 << 20);
        write_reg(REG_DUTY_UPPER, 32'd511);
        write_reg(REG_DUTY_LOWER, 32'd0);
      end
      PH_WINDUP_LO: write_reg(REG_SETPOINT, 32'd0);
      default: random_settings();
    endcase
    repeat (n_items) begin
      case (kind)
        PH_WINDUP_HI: fb = $urandom_range(0, 15);
        PH_WINDUP_LO: fb = $urandom_range(4080, 4095);
        default:      fb = pick_feedback();
      endcase
      send_sample(fb, 1'b0, '0);
    end
  endtask

  initial begin : out_stall_gen
    int r;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 999);
        if (r < 150) begin
          out_stall <= 1'b1;
        end else if (r < 152) begin
          // A long hold keeps a finished result waiting while the next sample is computed.
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 120)) @(negedge clk);
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (duty_expected.size() == 0) begin
        $error("duty result with no request pending: duty_cycle %0d", duty_cycle);
        mismatches++;
      end else begin
        seen_want = duty_expected.pop_front();
        if (duty_cycle !== seen_want.duty) begin
          $error("duty_cycle: expected %0d, got %0d", seen_want.duty, duty_cycle);
          mismatches++;
        end
        if (at_upper_limit !== seen_want.up) begin
          $error("at_upper_limit: expected %0d, got %0d", seen_want.up, at_upper_limit);
          mismatches++;
        end
        if (at_lower_limit !== seen_want.lo) begin
          $error("at_lower_limit: expected %0d, got %0d", seen_want.lo, at_lower_limit);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_seq
    plan_row_t plan[$];
    sp_reg = '0;
    eu_reg = 13'd4095;
    el_reg = 13'h1000;
    pdiv_reg = 12'd1;
    idiv_reg = 24'd1;
    du_reg = 9'd511;
    dl_reg = 9'd0;
    integ_acc = 0;
    duty_held = '0;

    // Right after reset the duty sits at the lower limit.
    plan.push_back(known_row(12'd0, 9'd0, 1'b0, 1'b1));
    plan.push_back(known_row(12'd4095, 9'd0, 1'b0, 1'b1));
    plan.push_back(reg_row(REG_SETPOINT, 32'd4095));
    plan.push_back(known_row(12'd0, 9'd511, 1'b1, 1'b0));
    plan.push_back(known_row(12'd4095, 9'd511, 1'b1, 1'b0));
    plan.push_back(reg_row(REG_SETPOINT, 32'd2048));
    plan.push_back(reg_row(REG_DUTY_UPPER, 32'd400));
    plan.push_back(reg_row(REG_DUTY_LOWER, 32'd100));
    plan.push_back(reg_row(REG_PROP_DIV, 32'd8));
    plan.push_back(reg_row(REG_INTEG_DIV, 32'd4096));
    plan.push_back(sample_row(12'd2048));
    plan.push_back(sample_row(12'd0));
    plan.push_back(sample_row(12'd4095));
    plan.push_back(sample_row(12'd2100));
    plan.push_back(sample_row(12'd2000));
    // Crossed error limits: the lower one wins.
    plan.push_back(reg_row(REG_ERROR_UPPER, 32'hFFFF_FFCE));
    plan.push_back(reg_row(REG_ERROR_LOWER, 32'd50));
    plan.push_back(sample_row(12'd1234));
    plan.push_back(sample_row(12'd3000));
    plan.push_back(reg_row(REG_ERROR_UPPER, 32'd100));
    plan.push_back(reg_row(REG_ERROR_LOWER, 32'hFFFF_FF9C));
    // Crossed duty limits: the upper one wins.
    plan.push_back(reg_row(REG_DUTY_UPPER, 32'd100));
    plan.push_back(reg_row(REG_DUTY_LOWER, 32'd200));
    plan.push_back(sample_row(12'd2048));
    plan.push_back(sample_row(12'd0));
    plan.push_back(reg_row(REG_UNUSED, 32'hFFFF_FFFF));
    // Zero divisors behave as one.
    plan.push_back(reg_row(REG_PROP_DIV, 32'd0));
    plan.push_back(reg_row(REG_INTEG_DIV, 32'd0));
    plan.push_back(reg_row(REG_DUTY_UPPER, 32'd511));
    plan.push_back(reg_row(REG_DUTY_LOWER, 32'd0));
    plan.push_back(sample_row(12'd2100));
    plan.push_back(sample_row(12'd1990));
    plan.push_back(reg_row(REG_PROP_DIV, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_INTEG_DIV, 32'hFFFF_FFFF));
    plan.push_back(sample_row(12'd0));
    plan.push_back(sample_row(12'd4095));
    plan.push_back(sample_row(12'd2048));

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].fb, plan[i].known, plan[i].want);
      end
    end

    repeat (4) run_phase(PH_RANDOM, 100);
    // One stretch with neither side idling.
    wait_idle();
    calm <= 1'b1;
    run_phase(PH_RANDOM, 150);
    wait_idle();
    calm <= 1'b0;
    // Drive the integrator far toward both ends.
    run_phase(PH_WINDUP_HI, 250);
    run_phase(PH_WINDUP_LO, 250);
    run_phase(PH_MAX, 40);
    run_phase(PH_MIN, 40);
    run_phase(PH_RANDOM, 100);

    wait_idle();
    repeat (2 * INTEGRATOR_BITS + 8) @(posedge clk);
    if (mismatches == 0 && duty_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/pdcr_pkg.sv
rtl/pdcr_divider.sv
rtl/pi_duty_cycle_regulator_top.sv
rtl/pdcr_checker.sv
test/pi_duty_cycle_regulator_top_tb.sv
